// File: rtl/core/tmcr_pkg.sv
`timescale 1ns / 1ps

package tmcr_pkg;

	// Number format: signed Q8.24
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 24;
	localparam int MAX_ATOMS = 64;

	// Widths of an exact shifted product and of a four-term sum
	localparam int PROD_W = 2 * WORD_BITS - FRAC_BITS;
	localparam int SUM_W  = WORD_BITS + 2;

	localparam int ATOM_W  = 7;
	localparam int PATH_W  = 64;
	localparam int PBIT_W  = 6;
	localparam int TRIG_W  = 26;
	localparam int CFG_W   = 64;
	localparam int CIDX_W  = 3;
	localparam int ENTRIES = 12;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [PROD_W-1:0]    prod_t;
	typedef logic signed [SUM_W-1:0]     sum_t;
	typedef logic [ATOM_W-1:0]           atom_t;

	localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam word_t ONE  = word_t'(64'sd1 <<< FRAC_BITS);

	// Reset values of the registers
	localparam atom_t ATOM_COUNT_RST = 7'd4;
	localparam atom_t FIRST_ATOM     = 7'd4;
	localparam logic signed [TRIG_W-1:0] COS_RST = 26'sd16777216;

	// Request codes
	localparam logic [1:0] REQ_LOAD_PLUS  = 2'd0;
	localparam logic [1:0] REQ_LOAD_MINUS = 2'd1;
	localparam logic [1:0] REQ_STEP       = 2'd2;
	localparam logic [1:0] REQ_RESTART    = 2'd3;

	// Register indexes
	localparam logic [CIDX_W-1:0] CFG_ATOM_COUNT = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_PATH_BITS  = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_DIST12     = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_DIST23     = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_COS_THETA3 = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_SIN_THETA3 = 3'd5;

	typedef struct packed {
		logic [1:0]   req_type;
		logic [3:0]   entry_index;
		logic signed [31:0] entry_value;
	} req_word_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [6:0]         atom_index;
	} pos_word_t;

	// Clamp a shifted product to the word
	function automatic word_t sat_prod(input prod_t v);
		logic [PROD_W-WORD_BITS:0] hi;
		begin
			hi = v[PROD_W-1:WORD_BITS-1];
			if (&hi || ~|hi) return v[WORD_BITS-1:0];
			return v[PROD_W-1] ? WMIN : WMAX;
		end
	endfunction

	// Clamp a sum to the word
	function automatic word_t sat_sum(input sum_t v);
		logic [SUM_W-WORD_BITS:0] hi;
		begin
			hi = v[SUM_W-1:WORD_BITS-1];
			if (&hi || ~|hi) return v[WORD_BITS-1:0];
			return v[SUM_W-1] ? WMIN : WMAX;
		end
	endfunction

	// Fixed-point product: exact, floor shift, then clamp
	function automatic word_t fx_mul(input word_t a, input word_t b);
		logic signed [2*WORD_BITS-1:0] p;
		begin
			p = a * b;
			return sat_prod(signed'(p[2*WORD_BITS-1:FRAC_BITS]));
		end
	endfunction

endpackage

// File: rtl/core/torsion_matrix_chain_realizer_core.sv
`timescale 1ns / 1ps

// Torsion matrix chain realizer: builds atom positions of one branch of a
// distance-geometry chain as a running 3x4 affine product.
// Channels: req_valid/req_ready/req_word carries load, step and restart
// words; pos_valid/pos_ready/pos_word returns one position per step that
// realizes an atom (atoms 4 up to atom_count, capped at 64). Loads and
// restarts, and steps past the end of the chain, return nothing.
// Configuration goes through cfg_we/cfg_index/cfg_data; the user must write it
// only while the block is idle, which the block does not enforce. Distances and
// angle take effect at the next restart. A word is first registered in the input
// stage; its position is then registered in the output register for pos_word.
// Throughput: one word per cycle unless a step waits on a stalled output. A step
// multiplies the 3x4 product by the selected torsion matrix combinationally on 36
// parallel 32x32 multipliers, and the new product feeds the next step directly.
// Reset: registers take their default values and the product is set to the
// base frame of the default geometry, atom counter 4. Matrix entries are
// undefined until loaded.
// Stall: when pos_ready is low, a finished position waits in the output
// register; loads and restarts still pass, and a step that realizes an atom waits in
// the input stage, which then drops req_ready.
module torsion_matrix_chain_realizer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  tmcr_pkg::req_word_t           req_word,
	output logic                          pos_valid,
	input  logic                          pos_ready,
	output tmcr_pkg::pos_word_t           pos_word,
	input  logic                          cfg_we,
	input  logic [tmcr_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [tmcr_pkg::CFG_W-1:0]    cfg_data
);

	// Configuration registers
	tmcr_pkg::atom_t                         atom_count_q;
	logic [tmcr_pkg::PATH_W-1:0]             path_bits_q;
	tmcr_pkg::word_t                         dist12_q;
	tmcr_pkg::word_t                         dist23_q;
	logic signed [tmcr_pkg::TRIG_W-1:0]      cos_q;
	logic signed [tmcr_pkg::TRIG_W-1:0]      sin_q;

	// Chain state
	tmcr_pkg::word_t  prod_q  [tmcr_pkg::ENTRIES];
	tmcr_pkg::word_t  plus_q  [tmcr_pkg::ENTRIES];
	tmcr_pkg::word_t  minus_q [tmcr_pkg::ENTRIES];
	tmcr_pkg::atom_t  cur_atom_q;

	// Input stage and output register
	tmcr_pkg::req_word_t req_s1;
	logic                req_valid_s1;
	tmcr_pkg::pos_word_t pos_q;
	logic                pos_valid_q;

	// Step control
	tmcr_pkg::atom_t             n_eff;
	tmcr_pkg::atom_t             bit_sel;
	logic                        use_minus;
	logic                        is_step;
	logic                        emit;
	logic                        go;
	tmcr_pkg::word_t             a_sel  [tmcr_pkg::ENTRIES];
	tmcr_pkg::word_t             next_b [tmcr_pkg::ENTRIES];
	tmcr_pkg::word_t             rs_b   [tmcr_pkg::ENTRIES];
	tmcr_pkg::word_t             ct;
	tmcr_pkg::word_t             st;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atom_count_q <= tmcr_pkg::ATOM_COUNT_RST;
			path_bits_q  <= '0;
			dist12_q     <= '0;
			dist23_q     <= '0;
			cos_q        <= tmcr_pkg::COS_RST;
			sin_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tmcr_pkg::CFG_ATOM_COUNT: atom_count_q <= cfg_data[tmcr_pkg::ATOM_W-1:0];
				tmcr_pkg::CFG_PATH_BITS:  path_bits_q  <= cfg_data[tmcr_pkg::PATH_W-1:0];
				tmcr_pkg::CFG_DIST12:     dist12_q     <= cfg_data[tmcr_pkg::WORD_BITS-1:0];
				tmcr_pkg::CFG_DIST23:     dist23_q     <= cfg_data[tmcr_pkg::WORD_BITS-1:0];
				tmcr_pkg::CFG_COS_THETA3: cos_q        <= cfg_data[tmcr_pkg::TRIG_W-1:0];
				tmcr_pkg::CFG_SIN_THETA3: sin_q        <= cfg_data[tmcr_pkg::TRIG_W-1:0];
				default: ;
			endcase
		end
	end

	// Decide whether the word in the input stage retires this cycle
	always_comb begin
		n_eff     = (atom_count_q > tmcr_pkg::atom_t'(tmcr_pkg::MAX_ATOMS))
			? tmcr_pkg::atom_t'(tmcr_pkg::MAX_ATOMS) : atom_count_q;
		bit_sel   = n_eff - cur_atom_q;
		use_minus = path_bits_q[bit_sel[tmcr_pkg::PBIT_W-1:0]];
		is_step   = req_s1.req_type == tmcr_pkg::REQ_STEP;
		emit      = is_step && (cur_atom_q <= n_eff);
		go        = req_valid_s1 && (!emit || !pos_valid_q || pos_ready);
		req_ready = !req_valid_s1 || go;
	end

	// Multiply the product by the selected torsion matrix
	always_comb begin
		tmcr_pkg::sum_t acc;
		for (int i = 0; i < tmcr_pkg::ENTRIES; i++) begin
			a_sel[i] = use_minus ? minus_q[i] : plus_q[i];
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 4; c++) begin
				acc = (c == 3) ? tmcr_pkg::sum_t'(prod_q[r*4+3]) : '0;
				for (int k = 0; k < 3; k++) begin
					acc = acc + tmcr_pkg::sum_t'(tmcr_pkg::fx_mul(prod_q[r*4+k], a_sel[k*4+c]));
				end
				next_b[r*4+c] = tmcr_pkg::sat_sum(acc);
			end
		end
	end

	// Build the base frame from the current geometry registers
	always_comb begin
		ct = tmcr_pkg::word_t'(cos_q);
		st = tmcr_pkg::word_t'(sin_q);
		rs_b[0]  = ct;
		rs_b[1]  = st;
		rs_b[2]  = '0;
		rs_b[3]  = tmcr_pkg::sat_sum(tmcr_pkg::sum_t'(tmcr_pkg::fx_mul(dist23_q, ct))
			- tmcr_pkg::sum_t'(dist12_q));
		rs_b[4]  = st;
		rs_b[5]  = tmcr_pkg::sat_sum(-tmcr_pkg::sum_t'(ct));
		rs_b[6]  = '0;
		rs_b[7]  = tmcr_pkg::fx_mul(dist23_q, st);
		rs_b[8]  = '0;
		rs_b[9]  = '0;
		rs_b[10] = -tmcr_pkg::ONE;
		rs_b[11] = '0;
	end

	// Capture the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req_word;
		end
	end

	// Advance the running product and atom counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q[0]  <= tmcr_pkg::word_t'(tmcr_pkg::COS_RST);
			prod_q[1]  <= '0;
			prod_q[2]  <= '0;
			prod_q[3]  <= '0;
			prod_q[4]  <= '0;
			prod_q[5]  <= -tmcr_pkg::word_t'(tmcr_pkg::COS_RST);
			prod_q[6]  <= '0;
			prod_q[7]  <= '0;
			prod_q[8]  <= '0;
			prod_q[9]  <= '0;
			prod_q[10] <= -tmcr_pkg::ONE;
			prod_q[11] <= '0;
			cur_atom_q <= tmcr_pkg::FIRST_ATOM;
		end else if (go) begin
			if (req_s1.req_type == tmcr_pkg::REQ_RESTART) begin
				prod_q     <= rs_b;
				cur_atom_q <= tmcr_pkg::FIRST_ATOM;
			end else if (emit) begin
				prod_q     <= next_b;
				cur_atom_q <= cur_atom_q + 1'b1;
			end
		end
	end

	// Load torsion matrix entries
	always_ff @(posedge clk) begin
		if (go && req_s1.entry_index < 4'(tmcr_pkg::ENTRIES)) begin
			if (req_s1.req_type == tmcr_pkg::REQ_LOAD_PLUS) begin
				plus_q[req_s1.entry_index] <= req_s1.entry_value;
			end
			if (req_s1.req_type == tmcr_pkg::REQ_LOAD_MINUS) begin
				minus_q[req_s1.entry_index] <= req_s1.entry_value;
			end
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_valid_q <= 1'b0;
		end else if (go && emit) begin
			pos_valid_q <= 1'b1;
		end else if (pos_ready) begin
			pos_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			pos_q.pos_x      <= next_b[3];
			pos_q.pos_y      <= next_b[7];
			pos_q.pos_z      <= next_b[11];
			pos_q.atom_index <= cur_atom_q;
		end
	end

	assign pos_valid = pos_valid_q;
	assign pos_word  = pos_q;

	// Checks
	a_atom_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_atom_q <= tmcr_pkg::atom_t'(tmcr_pkg::MAX_ATOMS + 1))
		else $error("atom counter past end of chain");

	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		(go && emit) |=> cur_atom_q == $past(cur_atom_q) + 1'b1)
		else $error("atom counter did not advance on a step");

	a_pos_index: assert property (@(posedge clk) disable iff (!arst_n)
		(go && emit) |=> pos_valid_q && pos_q.atom_index == $past(cur_atom_q))
		else $error("position tagged with wrong atom");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(go && req_s1.req_type == tmcr_pkg::REQ_RESTART) |=> cur_atom_q == tmcr_pkg::FIRST_ATOM)
		else $error("restart did not rewind the atom counter");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!pos_valid_q |-> req_ready)
		else $error("input stalled with an empty output register");

endmodule

// File: verif/tmcr_position_checker.sv
`timescale 1ns / 1ps

// Watches the request, position and register ports, predicts each atom
// position and compares it with what the core hands out.
module tmcr_position_checker
	import tmcr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  req_word_t           req_word,
	input  logic                pos_valid,
	input  logic                pos_ready,
	input  pos_word_t           pos_word,
	input  logic                cfg_we,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	output int                  fails,
	output int                  pending
);

	// Shadow copy of the chain state and the registers
	word_t                     frame_m [ENTRIES];
	word_t                     plus_m  [ENTRIES];
	word_t                     minus_m [ENTRIES];
	atom_t                     next_atom;
	atom_t                     chain_len;
	logic [PATH_W-1:0]         branch_word;
	word_t                     d12_r;
	word_t                     d23_r;
	logic signed [TRIG_W-1:0]  cos_r;
	logic signed [TRIG_W-1:0]  sin_r;

	pos_word_t                 expected_positions [$];

	function automatic word_t clamp_word(input longint v);
		if (v > longint'(WMAX)) return WMAX;
		if (v < longint'(WMIN)) return WMIN;
		return word_t'(v);
	endfunction

	// Exact product, floor shift by the fraction width, then clamp
	function automatic word_t fixed_mul(input word_t a, input word_t b);
		longint p;
		p = longint'(a) * longint'(b);
		return clamp_word(p >>> FRAC_BITS);
	endfunction

	// Rebuild the base frame from distances and bond angle
	task automatic rebase_frame();
		longint ct;
		longint st;
		ct = longint'(cos_r);
		st = longint'(sin_r);
		frame_m[0]  = clamp_word(ct);
		frame_m[1]  = clamp_word(st);
		frame_m[2]  = '0;
		frame_m[3]  = clamp_word(longint'(fixed_mul(d23_r, clamp_word(ct))) - longint'(d12_r));
		frame_m[4]  = clamp_word(st);
		frame_m[5]  = clamp_word(-ct);
		frame_m[6]  = '0;
		frame_m[7]  = fixed_mul(d23_r, clamp_word(st));
		frame_m[8]  = '0;
		frame_m[9]  = '0;
		frame_m[10] = clamp_word(-longint'(ONE));
		frame_m[11] = '0;
		next_atom   = FIRST_ATOM;
	endtask

	task automatic note_field(input string fname, input atom_t atom,
			input logic [31:0] exp_v, input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			fails++;
			$display("%0t: atom %0d %s expected %h got %h", $time, atom, fname,
				exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		word_t     nxt [ENTRIES];
		longint    acc;
		atom_t     lim;
		int        bitpos;
		logic      use_minus;
		word_t     a_ent;
		pos_word_t exp_w;
		if (!arst_n) begin
			chain_len   = ATOM_COUNT_RST;
			branch_word = '0;
			d12_r       = '0;
			d23_r       = '0;
			cos_r       = COS_RST;
			sin_r       = '0;
			for (int i = 0; i < ENTRIES; i++) begin
				plus_m[i]  = '0;
				minus_m[i] = '0;
			end
			rebase_frame();
			expected_positions.delete();
			fails   = 0;
			pending = 0;
		end else begin
			// Register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_ATOM_COUNT: chain_len   = cfg_data[ATOM_W-1:0];
					CFG_PATH_BITS:  branch_word = cfg_data[PATH_W-1:0];
					CFG_DIST12:     d12_r       = cfg_data[WORD_BITS-1:0];
					CFG_DIST23:     d23_r       = cfg_data[WORD_BITS-1:0];
					CFG_COS_THETA3: cos_r       = cfg_data[TRIG_W-1:0];
					CFG_SIN_THETA3: sin_r       = cfg_data[TRIG_W-1:0];
					default: ;
				endcase
			end

			// Compare a delivered position with the oldest prediction
			if (pos_valid && pos_ready) begin
				if (expected_positions.size() == 0) begin
					fails++;
					$display("%0t: position word with no prediction pending: expected none got %h",
						$time, pos_word);
				end else begin
					exp_w = expected_positions.pop_front();
					note_field("pos_x", exp_w.atom_index, exp_w.pos_x, pos_word.pos_x);
					note_field("pos_y", exp_w.atom_index, exp_w.pos_y, pos_word.pos_y);
					note_field("pos_z", exp_w.atom_index, exp_w.pos_z, pos_word.pos_z);
					note_field("atom_index", exp_w.atom_index, 32'(exp_w.atom_index),
						32'(pos_word.atom_index));
				end
			end

			// Predict the effect of an accepted request word
			if (req_valid && req_ready) begin
				case (req_word.req_type)
					REQ_LOAD_PLUS: begin
						if (req_word.entry_index < ENTRIES)
							plus_m[req_word.entry_index] = req_word.entry_value;
					end
					REQ_LOAD_MINUS: begin
						if (req_word.entry_index < ENTRIES)
							minus_m[req_word.entry_index] = req_word.entry_value;
					end
					REQ_RESTART: rebase_frame();
					default: begin
						lim = (chain_len < MAX_ATOMS) ? chain_len : atom_t'(MAX_ATOMS);
						if (next_atom <= lim) begin
							bitpos    = int'(lim) - int'(next_atom);
							use_minus = branch_word[bitpos];
							for (int r = 0; r < 3; r++) begin
								for (int col = 0; col < 4; col++) begin
									acc = 0;
									for (int k = 0; k < 3; k++) begin
										a_ent = use_minus ? minus_m[k*4+col] : plus_m[k*4+col];
										acc += longint'(fixed_mul(frame_m[r*4+k], a_ent));
									end
									if (col == 3) acc += longint'(frame_m[r*4+3]);
									nxt[r*4+col] = clamp_word(acc);
								end
							end
							for (int i = 0; i < ENTRIES; i++) frame_m[i] = nxt[i];
							exp_w.pos_x      = nxt[3];
							exp_w.pos_y      = nxt[7];
							exp_w.pos_z      = nxt[11];
							exp_w.atom_index = next_atom;
							expected_positions.push_back(exp_w);
							next_atom = next_atom + 1'b1;
						end
					end
				endcase
			end
			pending = expected_positions.size();
		end
	end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import tmcr_pkg::*;

	localparam int LIMIT      = 400000;
	localparam int STIM_ITEMS = 1300;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	req_word_t           req_word;
	logic                pos_valid;
	logic                pos_ready;
	pos_word_t           pos_word;
	logic                cfg_we;
	logic [CIDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	int                  fails;
	int                  pending;
	int                  items;
	int                  cycles;
	bit                  calm;
	logic [31:0]         extreme_vals [6];

	torsion_matrix_chain_realizer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.pos_valid (pos_valid),
		.pos_ready (pos_ready),
		.pos_word  (pos_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tmcr_position_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.pos_valid (pos_valid),
		.pos_ready (pos_ready),
		.pos_word  (pos_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog on the whole run
	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL torsion_matrix_chain_realizer_core");
		$finish;
	end

	// Position sink: random stall before each word
	initial begin : sink
		int stall;
		pos_ready = 1'b0;
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				pos_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pos_ready <= 1'b1;
			do @(posedge clk); while (!pos_valid);
		end
	end

	// Matrix entry: mostly rotation-sized, some full range, some extremes
	function automatic logic [31:0] pick_entry();
		int unsigned mode;
		mode = $urandom_range(0, 9);
		if (mode < 6) return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
		if (mode < 8) return $urandom;
		return extreme_vals[$urandom_range(0, 5)];
	endfunction

	// Send one request word; hold it until accepted
	task automatic push_word(input logic [1:0] kind, input logic [3:0] idx,
			input logic [31:0] val);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_word  <= '{req_type: kind, entry_index: idx, entry_value: val};
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		if (!((kind == REQ_LOAD_PLUS || kind == REQ_LOAD_MINUS) && idx >= ENTRIES))
			items++;
	endtask

	// Drop valid and wait for every predicted position plus the pipe depth
	task automatic settle();
		req_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// Write all six registers; unused upper data bits carry noise
	task automatic program_regs(input atom_t n, input logic [63:0] path,
			input logic [31:0] d12, input logic [31:0] d23,
			input logic [TRIG_W-1:0] c, input logic [TRIG_W-1:0] s);
		logic [63:0] pad;
		pad = {$urandom, $urandom};
		pad[ATOM_W-1:0] = n;
		write_reg(CFG_ATOM_COUNT, pad);
		write_reg(CFG_PATH_BITS, path);
		pad = {$urandom, $urandom};
		pad[31:0] = d12;
		write_reg(CFG_DIST12, pad);
		pad = {$urandom, $urandom};
		pad[31:0] = d23;
		write_reg(CFG_DIST23, pad);
		pad = {$urandom, $urandom};
		pad[TRIG_W-1:0] = c;
		write_reg(CFG_COS_THETA3, pad);
		pad = {$urandom, $urandom};
		pad[TRIG_W-1:0] = s;
		write_reg(CFG_SIN_THETA3, pad);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [TRIG_W-1:0] pick_trig();
		if ($urandom_range(0, 5) == 0) return TRIG_W'($urandom);
		return TRIG_W'($urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
	endfunction

	function automatic logic [31:0] pick_dist();
		if ($urandom_range(0, 5) == 0) return $urandom;
		return 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
	endfunction

	initial begin : stim
		atom_t             n_sel;
		logic [63:0]       path_sel;
		int                n_eff;
		int                steps;
		int                choice;
		bit                loaded;
		req_valid = 1'b0;
		req_word  = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		calm      = 1'b0;
		items     = 0;
		extreme_vals[0] = WMAX;
		extreme_vals[1] = WMIN;
		extreme_vals[2] = '0;
		extreme_vals[3] = ONE;
		extreme_vals[4] = -ONE;
		extreme_vals[5] = '1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset geometry, extreme plus entries, ignored loads, a step for atom 4,
		// a step past the chain end, then a restart and another step
		for (int i = 0; i < ENTRIES; i++)
			push_word(REQ_LOAD_PLUS, 4'(i), extreme_vals[(i * 5) % 6]);
		push_word(REQ_LOAD_PLUS, 4'd12, WMAX);
		push_word(REQ_LOAD_MINUS, 4'd15, WMIN);
		push_word(REQ_STEP, 4'd0, '0);
		push_word(REQ_STEP, 4'd15, '1);
		push_word(REQ_RESTART, 4'd9, WMAX);
		push_word(REQ_STEP, 4'd3, ONE);

		// Random phases: new registers, then well-formed chains with noise
		loaded = 1'b0;
		while (items < STIM_ITEMS) begin
			settle();
			calm   = ($urandom_range(0, 3) == 0);
			choice = $urandom_range(0, 9);
			if (choice == 0) begin
				n_sel = '1;
				path_sel = '1;
				program_regs(n_sel, path_sel, WMAX, WMIN, 26'h1FF_FFFF, 26'h200_0000);
			end else if (choice == 1) begin
				n_sel = '0;
				path_sel = '0;
				program_regs(n_sel, path_sel, WMIN, WMAX, 26'h200_0000, 26'h1FF_FFFF);
			end else if (choice == 2) begin
				n_sel = atom_t'(MAX_ATOMS);
				path_sel = {$urandom, $urandom};
				program_regs(n_sel, path_sel, pick_dist(), pick_dist(), pick_trig(), pick_trig());
			end else begin
				n_sel = ($urandom_range(0, 7) == 0) ? atom_t'($urandom) :
					atom_t'($urandom_range(4, 12));
				path_sel = {$urandom, $urandom};
				program_regs(n_sel, path_sel, pick_dist(), pick_dist(), pick_trig(), pick_trig());
			end
			n_eff = (n_sel < MAX_ATOMS) ? int'(n_sel) : MAX_ATOMS;

			repeat ($urandom_range(1, 3)) begin
				push_word(REQ_RESTART, 4'($urandom), $urandom);
				// Fill both matrices before the first step ever reads them
				if (!loaded || $urandom_range(0, 5) == 0) begin
					for (int i = 0; i < ENTRIES; i++)
						push_word(REQ_LOAD_PLUS, 4'(i), pick_entry());
					for (int i = 0; i < ENTRIES; i++)
						push_word(REQ_LOAD_MINUS, 4'(i), pick_entry());
					loaded = 1'b1;
				end
				steps = ((n_eff >= 4) ? n_eff - 3 : 0) + $urandom_range(0, 2);
				repeat (steps) begin
					repeat ($urandom_range(0, 3))
						push_word($urandom_range(0, 1) ? REQ_LOAD_MINUS : REQ_LOAD_PLUS,
							4'($urandom_range(0, ENTRIES - 1)), pick_entry());
					if ($urandom_range(0, 11) == 0)
						push_word(2'($urandom), 4'($urandom), $urandom);
					push_word(REQ_STEP, 4'($urandom), $urandom);
				end
				// Now and then hold off until the core has drained
				if ($urandom_range(0, 4) == 0) settle();
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("PASS torsion_matrix_chain_realizer_core");
		else
			$display("FAIL torsion_matrix_chain_realizer_core");
		$finish;
	end

endmodule

// File: torsion_matrix_chain_realizer_core.f
rtl/core/tmcr_pkg.sv
rtl/core/torsion_matrix_chain_realizer_core.sv
verif/tmcr_position_checker.sv
verif/tb.sv
